>>> src/utrx_pkg.sv
package utrx_pkg;

  // Width of the bit timers; cycles_per_bit bits above it are ignored.
  localparam int unsigned TIMER_W = 16;

  // Widths fixed by the register map and the stream payloads.
  localparam int unsigned CPB_W       = 16;
  localparam int unsigned STOP_W      = 32;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef logic [TIMER_W-1:0]   timer_t;
  typedef logic [CPB_W-1:0]     cpb_t;
  typedef logic [STOP_W-1:0]    stop_cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [3:0]           bit_cnt_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CFG_CYCLES_PER_BIT  = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_STOP_WAIT_TICKS = cfg_idx_t'(1);

  // Register reset values.
  localparam cpb_t      CPB_RESET       = cpb_t'(6076);
  localparam stop_cnt_t STOP_WAIT_RESET = '1;

  // Transmit frame: start bit, eight data bits, stop bit.
  localparam bit_cnt_t TX_FRAME_BITS = bit_cnt_t'(10);
  localparam bit_cnt_t RX_DATA_BITS  = bit_cnt_t'(8);

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_START,
    RX_DATA,
    RX_STOP
  } rx_phase_e;

endpackage

>>> src/uart_8n1_transceiver_top.sv
// Channel   Dir  Handshake                          Payload
// s_axis    in   s_axis_tvalid_i / s_axis_tready_o  one line tick: rx level, send request, byte
// m_axis    out  m_axis_tvalid_o / m_axis_tready_i  one result per tick: tx line, receive report
// cfg       in   cfg_valid_i / cfg_ready_o          register index and write data
//
// Every accepted tick yields exactly one result, which is registered in the output register.
// One tick is taken per cycle; the bound is the single output register, which is drained
// and refilled in the same cycle, so a stall on m_axis holds s_axis off directly.
// Reset clears the transmitter and receiver to idle and loads the register defaults.
// The configuration channel is always ready and takes effect on the next accepted tick.
module uart_8n1_transceiver_top
  import utrx_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [0] rx_level, [1] send_valid, [9:2] send_byte, [15:10] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [0] tx_level, [1] tx_busy, [2] recv_valid, [10:3] recv_byte, [11] recv_timeout,
  // [15:12] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // Configuration registers.
  cpb_t      cpb_q;
  stop_cnt_t stop_wait_q;

  // Transmitter state.
  logic [8:0] tx_shift_q, tx_shift_d;
  bit_cnt_t   tx_bits_q, tx_bits_d;
  timer_t     tx_tick_q, tx_tick_d;

  // Receiver state.
  rx_phase_e  rx_phase_q, rx_phase_d;
  timer_t     rx_tick_q, rx_tick_d;
  logic [7:0] rx_shift_q, rx_shift_d;
  bit_cnt_t   rx_bits_q, rx_bits_d;
  stop_cnt_t  stop_cnt_q, stop_cnt_d;
  logic       rx_prev_q, rx_prev_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Input fields.
  logic       in_rx;
  logic       in_send;
  logic [7:0] in_byte;
  logic       in_xfer;
  logic       cfg_xfer;

  // Bit times.
  timer_t cpb_m;
  timer_t bit_time;
  timer_t half_time;

  // Result fields.
  logic       tx_level;
  logic       tx_busy;
  logic       recv_valid;
  logic [7:0] recv_byte;
  logic       recv_timeout;

  assign in_rx   = s_axis_tdata_i[0];
  assign in_send = s_axis_tdata_i[1];
  assign in_byte = s_axis_tdata_i[9:2];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign cfg_xfer        = cfg_valid_i;

  assign cpb_m     = timer_t'(cpb_q);
  assign bit_time  = (cpb_m == '0) ? timer_t'(1) : cpb_m;
  assign half_time = cpb_m >> 1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpb_q       <= CPB_RESET;
      stop_wait_q <= STOP_WAIT_RESET;
    end else if (cfg_xfer) begin
      if (cfg_index_i == CFG_CYCLES_PER_BIT) begin
        cpb_q <= cfg_data_i[CPB_W-1:0];
      end else if (cfg_index_i == CFG_STOP_WAIT_TICKS) begin
        stop_wait_q <= cfg_data_i[STOP_W-1:0];
      end
    end
  end

  // Transmitter: load a frame when idle, drive the line, advance the bit timer.
  always_comb begin
    logic [8:0] shift;
    bit_cnt_t   bits;
    timer_t     tick;
    timer_t     tick_inc;

    shift = tx_shift_q;
    bits  = tx_bits_q;
    tick  = tx_tick_q;
    if (tx_bits_q == '0 && in_send) begin
      shift = {1'b1, in_byte};
      bits  = TX_FRAME_BITS;
      tick  = '0;
    end

    if (bits == '0) begin
      tx_level = 1'b1;
    end else if (bits == TX_FRAME_BITS) begin
      tx_level = 1'b0;
    end else begin
      tx_level = shift[0];
    end
    tx_busy = (bits != '0);

    tick_inc   = tick + timer_t'(1);
    tx_shift_d = shift;
    tx_bits_d  = bits;
    tx_tick_d  = tick;
    if (bits != '0) begin
      if (tick_inc >= bit_time || tick_inc == '0) begin
        tx_tick_d = '0;
        if (bits != TX_FRAME_BITS) begin
          tx_shift_d = {1'b1, shift[8:1]};
        end
        tx_bits_d = bits - bit_cnt_t'(1);
      end else begin
        tx_tick_d = tick_inc;
      end
    end
  end

  // Receiver next state: edge detect, mid-bit sampling, stop level wait.
  always_comb begin
    timer_t rx_tick_inc;

    rx_tick_inc = rx_tick_q + timer_t'(1);
    rx_phase_d  = rx_phase_q;
    rx_tick_d   = rx_tick_q;
    rx_shift_d  = rx_shift_q;
    rx_bits_d   = rx_bits_q;
    stop_cnt_d  = stop_cnt_q;
    rx_prev_d   = in_rx;

    unique case (rx_phase_q)
      RX_IDLE: begin
        if (rx_prev_q && !in_rx) begin
          rx_phase_d = RX_START;
          rx_tick_d  = '0;
          rx_bits_d  = '0;
          rx_shift_d = '0;
        end
      end
      RX_START: begin
        rx_tick_d = rx_tick_inc;
        if (rx_tick_inc >= half_time || rx_tick_inc == '0) begin
          rx_phase_d = RX_DATA;
          rx_tick_d  = '0;
        end
      end
      RX_DATA: begin
        rx_tick_d = rx_tick_inc;
        if (rx_tick_inc >= bit_time || rx_tick_inc == '0) begin
          rx_tick_d  = '0;
          rx_shift_d = {in_rx, rx_shift_q[7:1]};
          rx_bits_d  = rx_bits_q + bit_cnt_t'(1);
          if (rx_bits_d >= RX_DATA_BITS) begin
            rx_phase_d = RX_STOP;
            stop_cnt_d = '0;
          end
        end
      end
      RX_STOP: begin
        if (in_rx) begin
          rx_phase_d = RX_IDLE;
        end else if (stop_cnt_q >= stop_wait_q) begin
          rx_phase_d = RX_IDLE;
        end else begin
          stop_cnt_d = stop_cnt_q + stop_cnt_t'(1);
        end
      end
      default: begin
        rx_phase_d = RX_IDLE;
      end
    endcase
  end

  // Receiver report for this tick.
  always_comb begin
    recv_valid   = 1'b0;
    recv_byte    = '0;
    recv_timeout = 1'b0;
    if (rx_phase_q == RX_STOP) begin
      if (in_rx) begin
        recv_valid = 1'b1;
        recv_byte  = rx_shift_q;
      end else if (stop_cnt_q >= stop_wait_q) begin
        recv_valid   = 1'b1;
        recv_timeout = 1'b1;
      end
    end
  end

  // Output register: filled on an input transfer, emptied on an output transfer.
  always_comb begin
    out_data_d = {4'b0000, recv_timeout, recv_byte, recv_valid, tx_busy, tx_level};
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_shift_q  <= '1;
      tx_bits_q   <= '0;
      tx_tick_q   <= '0;
      rx_phase_q  <= RX_IDLE;
      rx_tick_q   <= '0;
      rx_shift_q  <= '0;
      rx_bits_q   <= '0;
      stop_cnt_q  <= '0;
      rx_prev_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        tx_shift_q <= tx_shift_d;
        tx_bits_q  <= tx_bits_d;
        tx_tick_q  <= tx_tick_d;
        rx_phase_q <= rx_phase_d;
        rx_tick_q  <= rx_tick_d;
        rx_shift_q <= rx_shift_d;
        rx_bits_q  <= rx_bits_d;
        stop_cnt_q <= stop_cnt_d;
        rx_prev_q  <= rx_prev_d;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
